// File: sv/abg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Alpha-beta-gamma tracker package
// Shared widths, filter constants, state machine encodings and the
// operation descriptor handed to the shared multiply-divide unit.
// ---------------------------------------------------------------------------
package abg_pkg;

	localparam int ANGLE_IN_W     = 32;
	localparam int ELAPSED_W      = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Internal arithmetic is signed 64 bits, saturated to +-(2^62 - 1).
	localparam int WIDE   = 64;
	localparam int MAG_W  = 62;
	localparam int HALF_W = MAG_W / 2;
	localparam int MUL_W  = 32;
	localparam int PROD_W = MAG_W + MUL_W;
	localparam int CNT_W  = $clog2(MAG_W);

	localparam int ALPHA_SHIFT = 24;
	localparam int GAMMA_SHIFT = 16;

	localparam logic [MUL_W-1:0] ALPHA_Q24 = MUL_W'(2780070);
	localparam logic [MUL_W-1:0] GAMMA_Q16 = MUL_W'(13320764);
	localparam logic [MUL_W-1:0] BETA_MS   = MUL_W'(15);
	localparam logic [MUL_W-1:0] MS_PER_S  = MUL_W'(1000);
	localparam logic [MUL_W-1:0] HALF_MS2  = MUL_W'(2000000);

	typedef logic signed [WIDE-1:0] wide_t;

	localparam wide_t INNER_LIM = wide_t'({{(WIDE-MAG_W){1'b0}}, {MAG_W{1'b1}}});

	typedef enum logic {
		KIND_DIVIDE,
		KIND_SHIFT
	} md_kind_t;

	typedef struct packed {
		wide_t            x;
		logic [MUL_W-1:0] m;
		logic [MUL_W-1:0] d;
		md_kind_t         kind;
		logic             post_shr;
	} md_op_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL_LO,
		MD_MUL_HI,
		MD_SETUP,
		MD_DIV,
		MD_FIX
	} md_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_RESID,
		ST_WRITE
	} abg_state_t;

	typedef enum logic [2:0] {
		STEP_VEL_PRED,
		STEP_ACC_POS,
		STEP_ACC_VEL,
		STEP_ALPHA,
		STEP_BETA,
		STEP_GAMMA
	} abg_step_t;

	function automatic wide_t clamp_inner(wide_t x);
		if (x > INNER_LIM) begin
			return INNER_LIM;
		end
		if (x < -INNER_LIM) begin
			return -INNER_LIM;
		end
		return x;
	endfunction

endpackage

// File: sv/abg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Alpha-beta-gamma tracker channels
// Valid/ready channels for measurement beats in and estimate beats out.
// ---------------------------------------------------------------------------
interface abg_sample_if;
	import abg_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_IN_W-1:0] measured_angle;
	logic        [ELAPSED_W-1:0]  elapsed_ms;

	modport source (output valid, output measured_angle, output elapsed_ms, input ready);
	modport sink (input valid, input measured_angle, input elapsed_ms, output ready);
endinterface

interface abg_result_if #(
	parameter int VALUE_WIDTH = abg_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] angle_estimate;
	logic signed [VALUE_WIDTH-1:0] rate_estimate;
	logic signed [VALUE_WIDTH-1:0] accel_estimate;
	logic                          was_first;
	logic                          clipped;
	logic                          zero_interval;

	modport source (
		output valid, output angle_estimate, output rate_estimate, output accel_estimate,
		output was_first, output clipped, output zero_interval, input ready
	);
	modport sink (
		input valid, input angle_estimate, input rate_estimate, input accel_estimate,
		input was_first, input clipped, input zero_interval, output ready
	);
endinterface

// File: sv/abg_muldiv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared multiply-divide unit
// Computes sign(x) * min(floor(|x| * m / d), 2^62 - 1) with a two-pass
// 31x32 multiplier and a restoring divider that retires one bit per cycle.
// A shift operation replaces the divide by a power of two.
// ---------------------------------------------------------------------------
module abg_muldiv (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  abg_pkg::md_op_t op,
	output logic           done,
	output abg_pkg::wide_t result
);
	import abg_pkg::*;

	md_state_t state_q, state_d;

	logic                  neg_q;
	logic [MAG_W-1:0]      mag_q;
	logic [MUL_W-1:0]      m_q;
	logic [MUL_W-1:0]      d_q;
	md_kind_t              kind_q;
	logic                  post_q;
	logic [PROD_W-1:0]     prod_q;
	logic [MUL_W-1:0]      rem_q;
	logic [MAG_W-1:0]      sh_q;
	logic [CNT_W-1:0]      cnt_q;

	wide_t                  cx;
	wide_t                  cx_abs;
	logic [HALF_W-1:0]      mul_a;
	logic [HALF_W+MUL_W-1:0] mul_p;
	logic [MUL_W:0]         trial;
	logic [MUL_W:0]         diff;
	logic                   ge;
	logic                   over;
	logic [MAG_W-1:0]       mag_out;
	wide_t                  mag_w;

	assign cx     = clamp_inner(op.x);
	assign cx_abs = cx[WIDE-1] ? -cx : cx;

	assign mul_a = (state_q == MD_MUL_HI) ? mag_q[MAG_W-1:HALF_W] : mag_q[HALF_W-1:0];
	assign mul_p = (HALF_W + MUL_W)'(mul_a) * (HALF_W + MUL_W)'(m_q);

	assign trial = {rem_q, sh_q[MAG_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};
	assign over  = prod_q[PROD_W-1:MAG_W] >= d_q;

	assign mag_out = post_q ? (sh_q >> GAMMA_SHIFT) : sh_q;
	assign mag_w   = wide_t'(mag_out);
	assign result  = neg_q ? -mag_w : mag_w;
	assign done    = (state_q == MD_FIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					state_d = MD_MUL_LO;
				end
			end
			MD_MUL_LO: state_d = MD_MUL_HI;
			MD_MUL_HI: state_d = MD_SETUP;
			MD_SETUP: begin
				if (kind_q == KIND_SHIFT || over) begin
					state_d = MD_FIX;
				end else begin
					state_d = MD_DIV;
				end
			end
			MD_DIV: begin
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					state_d = MD_FIX;
				end
			end
			MD_FIX: state_d = MD_IDLE;
			default: state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (start) begin
					neg_q  <= cx[WIDE-1];
					mag_q  <= cx_abs[MAG_W-1:0];
					m_q    <= op.m;
					d_q    <= op.d;
					kind_q <= op.kind;
					post_q <= op.post_shr;
				end
			end
			MD_MUL_LO: begin
				prod_q <= PROD_W'(mul_p);
			end
			MD_MUL_HI: begin
				prod_q <= prod_q + (PROD_W'(mul_p) << HALF_W);
			end
			MD_SETUP: begin
				if (kind_q == KIND_SHIFT) begin
					if (|prod_q[PROD_W-1:MAG_W+ALPHA_SHIFT]) begin
						sh_q <= '1;
					end else begin
						sh_q <= prod_q[MAG_W+ALPHA_SHIFT-1:ALPHA_SHIFT];
					end
				end else if (over) begin
					sh_q <= '1;
				end else begin
					rem_q <= prod_q[PROD_W-1:MAG_W];
					sh_q  <= prod_q[MAG_W-1:0];
					cnt_q <= '0;
				end
			end
			MD_DIV: begin
				rem_q <= ge ? diff[MUL_W-1:0] : trial[MUL_W-1:0];
				sh_q  <= {sh_q[MAG_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/alpha_beta_gamma_tracker.sv
`timescale 1ns / 1ps
// A first beat or a zero interval goes straight to the write state after acceptance.
// Any other beat runs five divides, one shift, a residual step and a write step, all
// through the one multiply-divide unit, whose divider retires one quotient bit per cycle;
// a saturated quotient skips the divide loop.
// A new beat is not taken until the last result has been loaded into the output register.
// Reset clears the filter state to zero and marks the filter as not yet initialized.
// ---------------------------------------------------------------------------
// Alpha-beta-gamma tracker
// Tracks one joint angle: predicts with constant acceleration and corrects
// position, rate and acceleration from the residual, saturating the results.
// ---------------------------------------------------------------------------
module alpha_beta_gamma_tracker #(
	parameter int VALUE_WIDTH = abg_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	abg_sample_if.sink          sample,
	abg_result_if.source        result
);
	import abg_pkg::*;

	localparam wide_t VALUE_MAX =
		wide_t'({{(WIDE-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
	localparam wide_t VALUE_MIN = -VALUE_MAX - wide_t'(1);

	abg_state_t state_q, state_d;
	abg_step_t  step_q, step_d;

	logic                          primed_q;
	logic signed [VALUE_WIDTH-1:0] angle_state_q;
	logic signed [VALUE_WIDTH-1:0] rate_state_q;
	logic signed [VALUE_WIDTH-1:0] accel_state_q;
	logic                          out_valid_q;

	logic signed [ANGLE_IN_W-1:0]  meas_q;
	logic [ELAPSED_W-1:0]          e_q;
	logic [2*ELAPSED_W-1:0]        e2_q;
	wide_t                         pp_q;
	wide_t                         pv_q;
	wide_t                         chg_q;
	logic                          first_q;
	logic                          clip_q;
	logic                          held_q;
	logic signed [VALUE_WIDTH-1:0] out_angle_q;
	logic signed [VALUE_WIDTH-1:0] out_rate_q;
	logic signed [VALUE_WIDTH-1:0] out_accel_q;
	logic                          out_first_q;
	logic                          out_clip_q;
	logic                          out_held_q;

	logic                          accept;
	logic                          out_load;
	logic                          md_start;
	logic                          md_done;
	md_op_t                        md_op;
	wide_t                         md_result;
	wide_t                         add_a;
	wide_t                         add_b;
	wide_t                         add_sat;
	logic signed [VALUE_WIDTH-1:0] add_val;
	logic                          add_hit;
	wide_t                         meas_in_w;
	logic signed [VALUE_WIDTH-1:0] meas_val;
	logic                          meas_hit;
	wide_t                         angle_w;
	wide_t                         rate_w;
	wide_t                         accel_w;

	assign angle_w = wide_t'(angle_state_q);
	assign rate_w  = wide_t'(rate_state_q);
	assign accel_w = wide_t'(accel_state_q);

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_WRITE) && (!out_valid_q || result.ready);

	assign result.valid          = out_valid_q;
	assign result.angle_estimate = out_angle_q;
	assign result.rate_estimate  = out_rate_q;
	assign result.accel_estimate = out_accel_q;
	assign result.was_first      = out_first_q;
	assign result.clipped        = out_clip_q;
	assign result.zero_interval  = out_held_q;

	// The first measurement is loaded directly, saturated to the value range.
	assign meas_in_w = wide_t'(sample.measured_angle);
	assign meas_hit  = (meas_in_w > VALUE_MAX) || (meas_in_w < VALUE_MIN);
	assign meas_val  = (meas_in_w > VALUE_MAX) ? VALUE_MAX[VALUE_WIDTH-1:0] :
		(meas_in_w < VALUE_MIN) ? VALUE_MIN[VALUE_WIDTH-1:0] : meas_in_w[VALUE_WIDTH-1:0];

	abg_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.op     (md_op),
		.done   (md_done),
		.result (md_result)
	);

	always_comb begin
		md_op.x        = chg_q;
		md_op.m        = MUL_W'(e_q);
		md_op.d        = MS_PER_S;
		md_op.kind     = KIND_DIVIDE;
		md_op.post_shr = 1'b0;
		case (step_q)
			STEP_VEL_PRED: begin
				md_op.x = rate_w;
			end
			STEP_ACC_POS: begin
				md_op.x = accel_w;
				md_op.m = MUL_W'(e2_q);
				md_op.d = HALF_MS2;
			end
			STEP_ACC_VEL: begin
				md_op.x = accel_w;
			end
			STEP_ALPHA: begin
				md_op.m    = ALPHA_Q24;
				md_op.kind = KIND_SHIFT;
			end
			STEP_BETA: begin
				md_op.m = BETA_MS;
				md_op.d = MUL_W'(e_q);
			end
			STEP_GAMMA: begin
				md_op.m        = GAMMA_Q16;
				md_op.d        = MUL_W'(e2_q);
				md_op.post_shr = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// One saturating adder serves every prediction, residual and correction sum.
	always_comb begin
		add_b = md_result;
		case (step_q)
			STEP_VEL_PRED: add_a = angle_w;
			STEP_ACC_POS:  add_a = pp_q;
			STEP_ACC_VEL:  add_a = rate_w;
			STEP_ALPHA:    add_a = pp_q;
			STEP_BETA:     add_a = pv_q;
			STEP_GAMMA:    add_a = accel_w;
			default:       add_a = pp_q;
		endcase
		if (state_q == ST_RESID) begin
			add_a = wide_t'(meas_q);
			add_b = -pp_q;
		end
		add_sat = clamp_inner(add_a + add_b);
		add_hit = (add_sat > VALUE_MAX) || (add_sat < VALUE_MIN);
		add_val = (add_sat > VALUE_MAX) ? VALUE_MAX[VALUE_WIDTH-1:0] :
			(add_sat < VALUE_MIN) ? VALUE_MIN[VALUE_WIDTH-1:0] : add_sat[VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_VEL_PRED;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		md_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!primed_q || sample.elapsed_ms == '0) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_ISSUE;
						step_d  = STEP_VEL_PRED;
					end
				end
			end
			ST_ISSUE: begin
				md_start = 1'b1;
				state_d  = ST_WAIT;
			end
			ST_WAIT: begin
				if (md_done) begin
					case (step_q)
						STEP_VEL_PRED: begin
							state_d = ST_ISSUE;
							step_d  = STEP_ACC_POS;
						end
						STEP_ACC_POS: begin
							state_d = ST_ISSUE;
							step_d  = STEP_ACC_VEL;
						end
						STEP_ACC_VEL: state_d = ST_RESID;
						STEP_ALPHA: begin
							state_d = ST_ISSUE;
							step_d  = STEP_BETA;
						end
						STEP_BETA: begin
							state_d = ST_ISSUE;
							step_d  = STEP_GAMMA;
						end
						STEP_GAMMA: state_d = ST_WRITE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RESID: begin
				state_d = ST_ISSUE;
				step_d  = STEP_ALPHA;
			end
			ST_WRITE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q      <= 1'b0;
			angle_state_q <= '0;
			rate_state_q  <= '0;
			accel_state_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept && !primed_q) begin
				primed_q      <= 1'b1;
				angle_state_q <= meas_val;
				rate_state_q  <= '0;
				accel_state_q <= '0;
			end
			if (state_q == ST_WAIT && md_done) begin
				case (step_q)
					STEP_ALPHA: angle_state_q <= add_val;
					STEP_BETA:  rate_state_q  <= add_val;
					STEP_GAMMA: accel_state_q <= add_val;
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meas_q  <= sample.measured_angle;
			e_q     <= sample.elapsed_ms;
			e2_q    <= (2*ELAPSED_W)'(sample.elapsed_ms) * (2*ELAPSED_W)'(sample.elapsed_ms);
			first_q <= !primed_q;
			held_q  <= primed_q && (sample.elapsed_ms == '0);
			clip_q  <= !primed_q && meas_hit;
		end
		if (state_q == ST_WAIT && md_done) begin
			case (step_q)
				STEP_VEL_PRED: pp_q <= add_sat;
				STEP_ACC_POS:  pp_q <= add_sat;
				STEP_ACC_VEL:  pv_q <= add_sat;
				default: begin
					if (add_hit) begin
						clip_q <= 1'b1;
					end
				end
			endcase
		end
		if (state_q == ST_RESID) begin
			chg_q <= add_sat;
		end
		if (out_load) begin
			out_angle_q <= angle_state_q;
			out_rate_q  <= rate_state_q;
			out_accel_q <= accel_state_q;
			out_first_q <= first_q;
			out_clip_q  <= clip_q;
			out_held_q  <= held_q;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Alpha-beta-gamma tracker testbench
// Drives measurement beats through the sample channel and checks every
// estimate beat against an in-bench fixed-point model of the filter. It
// covers the first sample, held zero intervals, saturation at the value
// limits, smooth joint trajectories with noise, and random back-pressure.
// ---------------------------------------------------------------------------
module tb;
	import abg_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	localparam longint INNER_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam longint VALUE_MAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
	localparam longint VALUE_MIN = -VALUE_MAX - 64'sd1;
	localparam longint unsigned ALPHA_NUM = 64'd2780070;
	localparam longint unsigned GAMMA_NUM = 64'd13320764;
	localparam longint unsigned BETA_NUM = 64'd15;
	localparam longint unsigned MS_SCALE = 64'd1000;
	localparam longint unsigned HALF_MS_SQ = 64'd2000000;

	typedef struct {
		logic signed [VW-1:0] angle;
		logic signed [VW-1:0] rate;
		logic signed [VW-1:0] accel;
		bit                   first;
		bit                   clip;
		bit                   held;
	} estimate_t;

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   stall_left;
	int   n_beats;
	int   n_estimates;
	int   n_saturated;
	int   n_held;
	int   n_first;
	int   n_errors;

	longint trk_angle;
	longint trk_rate;
	longint trk_accel;
	bit     trk_primed;

	estimate_t pending_estimates[$];

	abg_sample_if sample_ch ();
	abg_result_if #(.VALUE_WIDTH(VW)) result_ch ();

	alpha_beta_gamma_tracker #(.VALUE_WIDTH(VW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic longint limit_inner(longint x);
		if (x > INNER_MAX) begin
			return INNER_MAX;
		end
		if (x < -INNER_MAX) begin
			return -INNER_MAX;
		end
		return x;
	endfunction

	function automatic longint add_inner(longint x, longint y);
		return limit_inner(limit_inner(x) + limit_inner(y));
	endfunction

	function automatic longint scale_div(longint x, longint unsigned m, longint unsigned d);
		longint cx;
		bit neg;
		longint unsigned mag, q, r, res;
		cx = limit_inner(x);
		neg = cx < 0;
		mag = neg ? longint'(-cx) : cx;
		if (d == 0) begin
			return 0;
		end
		q = mag / d;
		r = mag % d;
		if (m != 0 && q > longint'(INNER_MAX) / m) begin
			res = INNER_MAX;
		end else begin
			res = q * m + (r * m) / d;
			if (res > INNER_MAX) begin
				res = INNER_MAX;
			end
		end
		return neg ? -longint'(res) : longint'(res);
	endfunction

	function automatic longint fit_value(longint x);
		if (x > VALUE_MAX) begin
			return VALUE_MAX;
		end
		if (x < VALUE_MIN) begin
			return VALUE_MIN;
		end
		return x;
	endfunction

	function automatic estimate_t track_sample(logic signed [31:0] meas_in, logic [15:0] ms);
		estimate_t est;
		longint meas, pp, pv, chg, np, nv, na;
		longint unsigned e, e2;
		meas = meas_in;
		e = ms;
		e2 = e * e;
		est.first = 1'b0;
		est.clip = 1'b0;
		est.held = 1'b0;
		if (!trk_primed) begin
			trk_angle = fit_value(meas);
			est.clip = trk_angle != meas;
			trk_rate = 0;
			trk_accel = 0;
			trk_primed = 1'b1;
			est.first = 1'b1;
		end else if (e == 0) begin
			est.held = 1'b1;
		end else begin
			pp = add_inner(add_inner(trk_angle, scale_div(trk_rate, e, MS_SCALE)),
				scale_div(trk_accel, e2, HALF_MS_SQ));
			pv = add_inner(trk_rate, scale_div(trk_accel, e, MS_SCALE));
			chg = add_inner(meas, -pp);
			np = add_inner(pp, scale_div(chg, ALPHA_NUM, 64'd1 << 24));
			nv = add_inner(pv, scale_div(chg, BETA_NUM, e));
			na = add_inner(trk_accel,
				scale_div(scale_div(chg, GAMMA_NUM, e2), 64'd1, 64'd1 << 16));
			est.clip = (np != fit_value(np)) || (nv != fit_value(nv)) || (na != fit_value(na));
			trk_angle = fit_value(np);
			trk_rate = fit_value(nv);
			trk_accel = fit_value(na);
		end
		est.angle = trk_angle[VW-1:0];
		est.rate = trk_rate[VW-1:0];
		est.accel = trk_accel[VW-1:0];
		return est;
	endfunction

	function automatic longint spread(int unsigned amp);
		return longint'($urandom_range(0, 2 * amp)) - longint'(amp);
	endfunction

	task automatic send_sample(input logic signed [31:0] angle, input logic [15:0] ms);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		pending_estimates.push_back(track_sample(angle, ms));
		sample_ch.valid <= 1'b1;
		sample_ch.measured_angle <= angle;
		sample_ch.elapsed_ms <= ms;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		n_beats++;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : check_estimates
		estimate_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_estimates.size() == 0) begin
				$display("%0t: estimate beat with none expected, actual angle %0d",
					$time, result_ch.angle_estimate);
				n_errors++;
			end else begin
				want = pending_estimates.pop_front();
				check_field("angle_estimate", want.angle, result_ch.angle_estimate);
				check_field("rate_estimate", want.rate, result_ch.rate_estimate);
				check_field("accel_estimate", want.accel, result_ch.accel_estimate);
				check_field("was_first", want.first, result_ch.was_first);
				check_field("clipped", want.clip, result_ch.clipped);
				check_field("zero_interval", want.held, result_ch.zero_interval);
				n_estimates++;
				n_saturated += want.clip;
				n_held += want.held;
				n_first += want.first;
			end
		end
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (!idle_on) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic run_trajectory(input int unsigned len);
		longint pos, vel, acc, dt, base_dt;
		int unsigned amp;
		logic signed [31:0] m;
		pos = spread(512 << 20);
		vel = spread(4 << 20);
		acc = spread(8 << 20);
		base_dt = $urandom_range(5, 60);
		amp = $urandom_range(0, 1 << 14);
		for (int i = 0; i < len; i++) begin
			dt = base_dt + longint'($urandom_range(0, 4));
			pos = pos + vel * dt / 1000 + acc * dt * dt / 2000000;
			vel = vel + acc * dt / 1000;
			if (pos > (1000 << 20) || pos < -(1000 << 20)) begin
				vel = -vel;
				acc = -acc;
			end
			if ($urandom_range(0, 19) == 0) begin
				m = $urandom;
			end else begin
				m = 32'(pos + spread(amp));
			end
			send_sample(m, ($urandom_range(0, 29) == 0) ? 16'd0 : dt[15:0]);
		end
	endtask

	task automatic test_first_sample();
		send_sample(32'sh7FFF_FFFF, 16'd0);
	endtask

	task automatic test_zero_interval();
		send_sample(32'sh8000_0000, 16'd0);
		send_sample(32'sd12345, 16'd0);
	endtask

	task automatic test_extremes();
		send_sample(32'sh8000_0000, 16'd1);
		send_sample(32'sh7FFF_FFFF, 16'd1);
		send_sample(32'sd0, 16'hFFFF);
		send_sample(32'sh7FFF_FFFF, 16'hFFFF);
		send_sample(32'sh8000_0000, 16'hFFFF);
		send_sample(32'sd1048576, 16'd1);
		send_sample(-32'sd1048576, 16'd2);
		send_sample(32'shFFFF_FFFF, 16'hFFFF);
		send_sample(32'sh5555_5555, 16'hAAAA);
		send_sample(32'shAAAA_AAAA, 16'h5555);
		for (int i = 0; i < 8; i++) begin
			send_sample(32'sd1048576, 16'd20);
		end
	endtask

	task automatic test_random_tracking(input int count);
		int stop_at;
		stop_at = n_beats + count;
		while (n_beats < stop_at) begin
			idle_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 2))
						0: send_sample($urandom, 16'($urandom_range(0, 65535)));
						1: send_sample($urandom, 16'd0);
						default: send_sample($urandom, 16'($urandom_range(1, 3)));
					endcase
				end
			end else begin
				run_trajectory($urandom_range(10, 60));
			end
		end
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		run_trajectory(60);
		run_trajectory(60);
	endtask

	initial begin
		arst_n = 1'b0;
		idle_on = 1'b0;
		trk_angle = 0;
		trk_rate = 0;
		trk_accel = 0;
		trk_primed = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.measured_angle = '0;
		sample_ch.elapsed_ms = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_sample();
		test_zero_interval();
		test_extremes();
		test_random_tracking(1800);
		test_steady_stream();
		sample_ch.valid <= 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Run covered %0d measurement beats and %0d estimate beats.", n_beats, n_estimates);
		$display("Saturated estimates: %0d, held intervals: %0d, initializing beats: %0d.",
			n_saturated, n_held, n_first);
		if (n_errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
